@@ sv/roc_auc_trapezoid_engine_defines.svh @@
// ----------------------------------------------------------------------------
// ROC AUC engine assertion macros
// Shared property shorthands for the checks in the top level.
// ----------------------------------------------------------------------------
`ifndef ROC_AUC_TRAPEZOID_ENGINE_DEFINES_SVH
`define ROC_AUC_TRAPEZOID_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the block clock outside reset.
`define ROC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock outside reset.
`define ROC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/roc_pkg.sv @@
// ----------------------------------------------------------------------------
// ROC AUC engine package
// Sizes, row and control types, status codes and controller states.
// ----------------------------------------------------------------------------
package roc_pkg;

    localparam int MAX_ROWS   = 1024;
    localparam int SCORE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CNT_W      = $clog2(MAX_ROWS + 1);
    localparam int AUC_W      = FRAC_BITS + 1;
    localparam int PN_W       = 2 * CNT_W;
    localparam int DEN_W      = PN_W + 1;
    localparam int PROD_W     = 2 * CNT_W + 1;
    localparam int ACC_W      = 44;
    localparam int QCNT_W     = $clog2(AUC_W + 1);

    // One stored row: order key (sign flipped) and label.
    typedef struct packed {
        logic [SCORE_BITS-1:0] key;
        logic                  lab;
    } t_row;

    // Per-cycle command broadcast to every sorter cell.
    typedef struct packed {
        logic ld;  // insert the broadcast row
        logic sh;  // shift toward cell zero
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EQUAL  = 2'd1,
        ST_SINGLE = 2'd2,
        ST_OVF    = 2'd3
    } t_status;

    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_CHK  = 7'b0000010,
        S_WALK = 7'b0000100,
        S_PN   = 7'b0001000,
        S_PREP = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

endpackage

@@ sv/roc_cell.sv @@
// ----------------------------------------------------------------------------
// ROC AUC sorter cell
// One slot of the systolic insertion sorter; also shifts toward cell zero.
// ----------------------------------------------------------------------------
module roc_cell (
    input  logic               i_clk,
    input  roc_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,     // slot holds a row
    input  logic               i_slot,    // slot index is at most the row count
    input  roc_pkg::t_row      i_new,
    input  roc_pkg::t_row      i_left,
    input  logic               i_left_gt,
    input  roc_pkg::t_row      i_right,
    output roc_pkg::t_row      o_row,
    output logic               o_gt
);

    roc_pkg::t_row r_row;

    // An empty slot counts as greater than any key.
    assign o_gt  = !i_occ || (r_row.key > i_new.key);
    assign o_row = r_row;

    // Insert: take the neighbor's row when it also moves, else the new row.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld && i_slot && o_gt) begin
            r_row <= i_left_gt ? i_left : i_new;
        end else if (i_ctl.sh) begin
            r_row <= i_right;
        end
    end

endmodule

@@ sv/roc_div.sv @@
// ----------------------------------------------------------------------------
// ROC AUC divider
// Restoring divider, one quotient bit per cycle, quotient of AUC_W bits.
// ----------------------------------------------------------------------------
module roc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [roc_pkg::ACC_W-1:0]   i_num,
    input  logic [roc_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [roc_pkg::AUC_W-1:0]   o_quo
);

    logic [roc_pkg::ACC_W-1:0]  r_rem;
    logic [roc_pkg::ACC_W-1:0]  r_dsh;
    logic [roc_pkg::AUC_W-1:0]  r_quo;
    logic [roc_pkg::QCNT_W-1:0] r_cnt;
    logic                       r_done;
    logic                       w_fit;

    assign w_fit  = r_rem >= r_dsh;
    assign o_done = r_done;
    assign o_quo  = r_quo;

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= roc_pkg::QCNT_W'(roc_pkg::AUC_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == roc_pkg::QCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder, shifted divisor and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= roc_pkg::ACC_W'(i_den) << roc_pkg::FRAC_BITS;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[roc_pkg::AUC_W-2:0], w_fit};
        end
    end

endmodule

@@ sv/roc_auc_trapezoid_engine.sv @@
// ----------------------------------------------------------------------------
// ROC AUC trapezoid engine
// Sorts one column of scored rows and computes its area under the ROC curve.
// ----------------------------------------------------------------------------
// Usage: rows enter on the s_axis channel, score in tdata, label in tuser,
// tlast on the final row of the column. Rows are taken one per cycle while
// the engine loads; each row is inserted into a row of sorter cells in the
// same cycle. After the row with tlast the input stalls while the engine
// shifts the sorted rows out of cell zero, one per cycle, accumulating the
// trapezoid sum, then forms P*N and runs a 17-step divider. The special
// cases (overflow, all scores equal, single class) skip the walk and the
// divider and pass from the check state straight to the result register.
// One result per column leaves on m_axis: auc in tdata[16:0], status in
// tdata[18:17]. The result sits in an output register, so the next column
// may start loading while it waits; a column's result waits for that
// register to drain when the receiver stalls. Reset empties the sorter and
// clears the counters, flags and the output register.
// ----------------------------------------------------------------------------
`include "roc_auc_trapezoid_engine_defines.svh"

module roc_auc_trapezoid_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] score
    input  logic [0:0]  s_axis_tuser,   // [0] label
    input  logic        s_axis_tlast,   // last_row
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [16:0] auc, [18:17] status, rest zero
);

    localparam int N = roc_pkg::MAX_ROWS;
    localparam int CW = roc_pkg::CNT_W;

    roc_pkg::t_state            r_state;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_pos;
    logic                       r_ovf;
    logic [roc_pkg::SCORE_BITS-1:0] r_min;
    logic [roc_pkg::SCORE_BITS-1:0] r_max;
    logic [roc_pkg::ACC_W-1:0]  r_acc;
    logic [CW-1:0]              r_idx;
    logic [CW-1:0]              r_seen;
    logic [CW-1:0]              r_seen_pos;
    logic [CW-1:0]              r_tp_prev;
    logic [CW-1:0]              r_fp_prev;
    logic [roc_pkg::PROD_W-1:0] r_prod;
    logic                       r_prod_v;
    logic [roc_pkg::PN_W-1:0]   r_pn;
    logic                       r_div_start;
    logic                       r_out_v;
    logic [roc_pkg::AUC_W-1:0]  r_auc;
    roc_pkg::t_status           r_status;
    logic [roc_pkg::AUC_W-1:0]  r_res_auc;
    roc_pkg::t_status           r_res_status;

    roc_pkg::t_row              w_new;
    roc_pkg::t_cell_ctl         w_ctl;
    roc_pkg::t_row              w_row [N];
    logic                       w_gt  [N];
    logic                       w_acc_in;
    logic                       w_full;
    logic [CW-1:0]              w_neg;
    logic [CW-1:0]              w_seen_n;
    logic [CW-1:0]              w_seen_pos_n;
    logic [CW-1:0]              w_tp;
    logic [CW-1:0]              w_fp;
    logic                       w_grp_end;
    logic                       w_div_done;
    logic [roc_pkg::AUC_W-1:0]  w_quo;
    logic                       w_out_free;

    assign s_axis_tready = (r_state == roc_pkg::S_LOAD);
    assign w_acc_in      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CW'(N));
    assign w_new.key     = {~s_axis_tdata[31], s_axis_tdata[30:0]};
    assign w_new.lab     = s_axis_tuser[0];
    assign w_ctl.ld      = w_acc_in && !w_full;
    assign w_ctl.sh      = (r_state == roc_pkg::S_WALK);
    assign w_neg         = r_count - r_pos;
    assign w_out_free    = !r_out_v || m_axis_tready;

    // Sorter cell row; cell zero is the lowest key.
    for (genvar g = 0; g < N; g++) begin : g_cell
        roc_pkg::t_row w_left;
        roc_pkg::t_row w_right;
        logic          w_left_gt;
        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_gt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_row[g-1];
            assign w_left_gt = w_gt[g-1];
        end
        if (g == N - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_row[g+1];
        end
        roc_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_occ    (r_count > CW'(g)),
            .i_slot   (r_count >= CW'(g)),
            .i_new    (w_new),
            .i_left   (w_left),
            .i_left_gt(w_left_gt),
            .i_right  (w_right),
            .o_row    (w_row[g]),
            .o_gt     (w_gt[g])
        );
    end

    // Group walk over the row leaving cell zero.
    assign w_seen_n     = r_seen + 1'b1;
    assign w_seen_pos_n = r_seen_pos + CW'(w_row[0].lab);
    assign w_tp         = r_pos - w_seen_pos_n;
    assign w_fp         = w_neg - (w_seen_n - w_seen_pos_n);
    assign w_grp_end    = (r_idx == r_count - 1'b1) || (w_row[1].key != w_row[0].key);

    roc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_num  (roc_pkg::ACC_W'(r_acc << roc_pkg::FRAC_BITS) + roc_pkg::ACC_W'(r_pn)),
        .i_den  ({r_pn, 1'b0}),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    // Walk datapath: group product, then accumulate.
    always_ff @(posedge i_clk) begin
        if (r_state == roc_pkg::S_CHK) begin
            r_tp_prev  <= r_pos;
            r_fp_prev  <= w_neg;
            r_seen     <= '0;
            r_seen_pos <= '0;
            r_idx      <= '0;
        end else if (r_state == roc_pkg::S_WALK) begin
            r_seen     <= w_seen_n;
            r_seen_pos <= w_seen_pos_n;
            r_idx      <= r_idx + 1'b1;
            if (w_grp_end) begin
                r_prod    <= roc_pkg::PROD_W'(r_fp_prev - w_fp)
                                * roc_pkg::PROD_W'({1'b0, w_tp} + {1'b0, r_tp_prev});
                r_tp_prev <= w_tp;
                r_fp_prev <= w_fp;
            end
        end
        if (r_state == roc_pkg::S_PN) begin
            r_pn <= roc_pkg::PN_W'(r_pos) * roc_pkg::PN_W'(w_neg);
        end
    end

    // Controller, run counters and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= roc_pkg::S_LOAD;
            r_count      <= '0;
            r_pos        <= '0;
            r_ovf        <= 1'b0;
            r_acc        <= '0;
            r_prod_v     <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_v      <= 1'b0;
            r_auc        <= '0;
            r_status     <= roc_pkg::ST_OK;
            r_res_auc    <= '0;
            r_res_status <= roc_pkg::ST_OK;
            r_min        <= '0;
            r_max        <= '0;
        end else begin
            r_div_start <= (r_state == roc_pkg::S_PREP);
            r_prod_v    <= (r_state == roc_pkg::S_WALK) && w_grp_end;
            if (r_prod_v) begin
                r_acc <= r_acc + roc_pkg::ACC_W'(r_prod);
            end
            // The output register loads from the finished run or drains.
            if (r_state == roc_pkg::S_DONE && w_out_free) begin
                r_out_v  <= 1'b1;
                r_auc    <= r_res_auc;
                r_status <= r_res_status;
            end else if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                roc_pkg::S_LOAD: begin
                    if (w_acc_in) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                            r_pos   <= r_pos + CW'(w_new.lab);
                            if (r_count == '0 || w_new.key < r_min) begin
                                r_min <= w_new.key;
                            end
                            if (r_count == '0 || w_new.key > r_max) begin
                                r_max <= w_new.key;
                            end
                        end
                        if (s_axis_tlast) begin
                            r_state <= roc_pkg::S_CHK;
                        end
                    end
                end
                roc_pkg::S_CHK: begin
                    r_acc <= '0;
                    if (r_ovf) begin
                        r_res_auc    <= '0;
                        r_res_status <= roc_pkg::ST_OVF;
                        r_state      <= roc_pkg::S_DONE;
                    end else if (r_min == r_max) begin
                        r_res_auc    <= roc_pkg::AUC_W'(1) << (roc_pkg::FRAC_BITS - 1);
                        r_res_status <= roc_pkg::ST_EQUAL;
                        r_state      <= roc_pkg::S_DONE;
                    end else if (r_pos == '0 || w_neg == '0) begin
                        r_res_auc    <= '0;
                        r_res_status <= roc_pkg::ST_SINGLE;
                        r_state      <= roc_pkg::S_DONE;
                    end else begin
                        r_state <= roc_pkg::S_WALK;
                    end
                end
                roc_pkg::S_WALK: begin
                    if (r_idx == r_count - 1'b1) begin
                        r_state <= roc_pkg::S_PN;
                    end
                end
                roc_pkg::S_PN: begin
                    r_state <= roc_pkg::S_PREP;
                end
                roc_pkg::S_PREP: begin
                    r_state <= roc_pkg::S_DIV;
                end
                roc_pkg::S_DIV: begin
                    if (w_div_done) begin
                        r_res_auc    <= w_quo;
                        r_res_status <= roc_pkg::ST_OK;
                        r_state      <= roc_pkg::S_DONE;
                    end
                end
                roc_pkg::S_DONE: begin
                    if (w_out_free) begin
                        r_count <= '0;
                        r_pos   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= roc_pkg::S_LOAD;
                    end
                end
                default: begin
                    r_state <= roc_pkg::S_LOAD;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {5'd0, r_status, r_auc};

    // Checks on the row count, run sequencing and result range.
    `ROC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(N), "row count beyond store depth")
    `ROC_ASSERT_NEXT(a_last_to_chk, w_acc_in && s_axis_tlast, r_state == roc_pkg::S_CHK,
        "last row did not start the finish")
    `ROC_ASSERT_NOW(a_auc_range, r_out_v,
        r_auc <= (roc_pkg::AUC_W'(1) << roc_pkg::FRAC_BITS), "AUC above one")
    `ROC_ASSERT_NOW(a_walk_nonempty, r_state == roc_pkg::S_WALK, r_idx < r_count,
        "walk ran past the stored rows")

endmodule
